>>> rtl/core/sbh_pkg.sv
// Shared constants, types and helpers of the string bucket hash block.
package sbh_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BYTE_W = 8;

  localparam logic [WORD_W-1:0] MIX_SEED  = 32'h1234_5678;
  localparam logic [WORD_W-1:0] MIX_MUL   = 32'h5bd1_e995;
  localparam int unsigned       MIX_SHIFT = 15;
  localparam logic [WORD_W-1:0] LEN_LIMIT = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] LEN_MAX   = 32'hffff_ffff;

  // Control from the sequencer to the remainder unit.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // Status from the remainder unit back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [WORD_W-1:0] sext8(input logic [BYTE_W-1:0] b);
    return {{(WORD_W-BYTE_W){b[BYTE_W-1]}}, b};
  endfunction

endpackage

>>> rtl/core/sbh_divider.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
module sbh_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sbh_pkg::div_ctrl_t             ctrl_i,
  input  logic [sbh_pkg::WORD_W-1:0]     dividend_i,
  input  logic [sbh_pkg::WORD_W-1:0]     divisor_i,
  output sbh_pkg::div_stat_t             stat_o,
  output logic [sbh_pkg::WORD_W-1:0]     remainder_o
);

  localparam int unsigned CntW = $clog2(sbh_pkg::WORD_W);
  localparam logic [CntW-1:0] CntLast = CntW'(sbh_pkg::WORD_W - 1);

  logic [sbh_pkg::WORD_W-1:0] rem_q;
  logic [sbh_pkg::WORD_W-1:0] num_q;
  logic [sbh_pkg::WORD_W-1:0] den_q;
  logic [CntW-1:0]            cnt_q;
  logic                       busy_q;
  logic                       done_q;
  logic [sbh_pkg::WORD_W:0]   trial;
  logic [sbh_pkg::WORD_W:0]   diff;
  logic                       fits;

  // Bring down the next dividend bit and subtract the divisor where it fits.
  assign trial = {rem_q, num_q[sbh_pkg::WORD_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q <= '0;
      num_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[sbh_pkg::WORD_W-1:0] : trial[sbh_pkg::WORD_W-1:0];
      num_q <= {num_q[sbh_pkg::WORD_W-2:0], 1'b0};
    end
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign remainder_o  = rem_q;

`ifndef SYNTHESIS
  // The result is flagged only as the last step retires.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("remainder done without a preceding busy step");
`endif

endmodule

>>> rtl/core/string_bucket_hash.sv
// Top level of the string bucket hash: byte intake, mix sequencer and result stage.
//
// The block takes the bytes of a key one request at a time and gives one bucket
// index for each key, when the byte marked by tlast has been taken in. Every
// nonzero byte is folded into a 32-bit running mix (xor with the sign-extended
// byte, multiply by a fixed odd constant, then xor with itself shifted right by
// fifteen); zero bytes are ignored, though a zero byte with tlast still ends the
// key. The first, second, second-last and last bytes and a saturating length
// are kept alongside; at the end of the key the mix's upper half and a low half
// set by the second-last and last bytes and the length form a 32-bit hash, taken
// modulo bucket_count if nonzero. An all-zero key gives index 0 with tuser set.
// Timing: the block works on one byte at a time and holds s_axis_tready low
// meanwhile. A zero byte needs no fold; for a nonzero byte the accepting cycle
// registers the product of the single 32x32 multiplier, the next one folds it
// back into the mix. At the end of a key ST_FINISH forms the hash, ST_DIV lets
// the restoring remainder unit reduce it, one bit per cycle, when bucket_count
// and the length are nonzero, and ST_HOLD moves it into the output register. The
// output register lets a finished result wait for m_axis_tready while the next
// key streams in; a second result then waits until the first has been taken.
// bucket_count is written through the cfg port, which is always ready; write it
// only while no key is in progress and no result is outstanding.
module string_bucket_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel: bucket_count.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  // Key byte stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] key_byte
  input  logic        s_axis_tlast,   // last byte of the key
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] bucket_index
  output logic        m_axis_tuser    // [0] key_empty
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_FINISH,
    ST_DIV,
    ST_HOLD
  } state_e;

  state_e state_q;

  logic [sbh_pkg::WORD_W-1:0] bucket_count_q;
  logic [sbh_pkg::WORD_W-1:0] mix_q;
  logic [sbh_pkg::WORD_W-1:0] prod_q;
  logic [sbh_pkg::WORD_W-1:0] len_q;
  logic [sbh_pkg::BYTE_W-1:0] first_q;
  logic [sbh_pkg::BYTE_W-1:0] second_q;
  logic [sbh_pkg::BYTE_W-1:0] prev_q;
  logic [sbh_pkg::BYTE_W-1:0] lastc_q;
  logic                       end_pend_q;
  logic [sbh_pkg::WORD_W-1:0] res_q;
  logic                       res_empty_q;
  logic                       out_valid_q;
  logic [sbh_pkg::WORD_W-1:0] out_data_q;
  logic                       out_empty_q;

  logic                       in_accept;
  logic                       byte_nz;
  logic [sbh_pkg::WORD_W-1:0] prod_d;
  logic [sbh_pkg::WORD_W-1:0] mix_d;
  logic                       longer;
  logic [sbh_pkg::BYTE_W-1:0] sel_second;
  logic [sbh_pkg::BYTE_W-1:0] sel_prev;
  logic [sbh_pkg::WORD_W-1:0] edge_word;
  logic [sbh_pkg::WORD_W-1:0] len_word;
  logic [sbh_pkg::WORD_W-1:0] hash_raw;
  logic                       out_free;
  logic                       out_load;

  sbh_pkg::div_ctrl_t         div_ctrl;
  sbh_pkg::div_stat_t         div_stat;
  logic [sbh_pkg::WORD_W-1:0] div_rem;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign byte_nz       = (s_axis_tdata != '0);

  // One multiplication per nonzero byte; the shift-xor is done from the product register in ST_FOLD.
  assign prod_d = (mix_q ^ sbh_pkg::sext8(s_axis_tdata)) * sbh_pkg::MIX_MUL;
  assign mix_d  = prod_q ^ (prod_q >> sbh_pkg::MIX_SHIFT);

  // End of key: a single-byte key uses its first byte in every position.
  assign longer     = (len_q > sbh_pkg::WORD_W'(1));
  assign sel_second = longer ? second_q : first_q;
  assign sel_prev   = longer ? prev_q : first_q;
  assign edge_word  = {first_q, 24'h0}
                    | (sbh_pkg::sext8(sel_second) << 16)
                    | (sbh_pkg::sext8(sel_prev) << 8)
                    | sbh_pkg::sext8(lastc_q);
  assign len_word   = (len_q < sbh_pkg::LEN_LIMIT) ? ~len_q : len_q;
  assign hash_raw   = {mix_q[31:16], edge_word[15:0] ^ len_word[15:0]};

  assign div_ctrl.start = (state_q == ST_FINISH) && (len_q != '0)
                        && (bucket_count_q != '0);

  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = (state_q == ST_HOLD) && out_free;

  sbh_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (div_ctrl),
    .dividend_i  (hash_raw),
    .divisor_i   (bucket_count_q),
    .stat_o      (div_stat),
    .remainder_o (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bucket_count_q <= cfg_data_i;
    end
  end

  // Sequencer, per-key state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mix_q       <= sbh_pkg::MIX_SEED;
      len_q       <= '0;
      first_q     <= '0;
      second_q    <= '0;
      prev_q      <= '0;
      lastc_q     <= '0;
      end_pend_q  <= 1'b0;
      res_q       <= '0;
      res_empty_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_empty_q <= 1'b0;
    end else begin
      // A new result may replace the one being taken in the same cycle.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            end_pend_q <= s_axis_tlast;
            if (byte_nz) begin
              if (len_q == '0) begin
                first_q <= s_axis_tdata;
              end else if (len_q == sbh_pkg::WORD_W'(1)) begin
                second_q <= s_axis_tdata;
              end
              prev_q  <= lastc_q;
              lastc_q <= s_axis_tdata;
              if (len_q != sbh_pkg::LEN_MAX) begin
                len_q <= len_q + 1'b1;
              end
              state_q <= ST_FOLD;
            end else if (s_axis_tlast) begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_FOLD: begin
          mix_q   <= mix_d;
          state_q <= end_pend_q ? ST_FINISH : ST_IDLE;
        end
        ST_FINISH: begin
          if (len_q == '0) begin
            res_empty_q <= 1'b1;
            res_q       <= '0;
            state_q     <= ST_HOLD;
          end else begin
            res_empty_q <= 1'b0;
            res_q       <= hash_raw;
            state_q     <= (bucket_count_q != '0) ? ST_DIV : ST_HOLD;
          end
          // The hash operands are captured now, so the key state can restart.
          mix_q    <= sbh_pkg::MIX_SEED;
          len_q    <= '0;
          first_q  <= '0;
          second_q <= '0;
          prev_q   <= '0;
          lastc_q  <= '0;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            res_q   <= div_rem;
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_data_q  <= res_q;
            out_empty_q <= res_empty_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // The multiplier product is a pure payload register.
  always_ff @(posedge clk_i) begin
    if (in_accept && byte_nz) begin
      prod_q <= prod_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_empty_q;

`ifndef SYNTHESIS
  a_div_start_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.start |=> (state_q == ST_DIV) && div_stat.busy)
    else $error("remainder unit started outside the end of a key");

  a_nz_byte_folds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && byte_nz |=> (state_q == ST_FOLD))
    else $error("nonzero byte not folded into the mix");

  a_idle_unit_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_stat.busy && !div_stat.done)
    else $error("remainder unit active while taking key bytes");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == '0))
    else $error("empty key result with a nonzero index");
`endif

endmodule

>>> dv/string_bucket_hash_checker.sv
// Checker for the string bucket hash: predicts bucket indices from the key byte stream.
module string_bucket_hash_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,
  input  logic        m_tuser_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [sbh_pkg::WORD_W-1:0] bucket_index;
    logic                       key_empty;
  } bucket_result_t;

  bucket_result_t awaited_buckets[$];
  bucket_result_t oldest_bucket;

  logic [sbh_pkg::WORD_W-1:0] bucket_count_q = '0;
  logic [sbh_pkg::WORD_W-1:0] mix_word       = sbh_pkg::MIX_SEED;
  logic [sbh_pkg::WORD_W-1:0] key_length     = '0;
  logic [sbh_pkg::BYTE_W-1:0] first_char     = '0;
  logic [sbh_pkg::BYTE_W-1:0] second_char    = '0;
  logic [sbh_pkg::BYTE_W-1:0] prev_char      = '0;
  logic [sbh_pkg::BYTE_W-1:0] last_char      = '0;

  int unsigned mismatches = 0;
  int unsigned waiting    = 0;

  assign error_count_o = mismatches;
  assign pending_o     = waiting;

  function automatic logic [sbh_pkg::WORD_W-1:0] sign_widen(
    input logic [sbh_pkg::BYTE_W-1:0] c
  );
    return {{(sbh_pkg::WORD_W-sbh_pkg::BYTE_W){c[sbh_pkg::BYTE_W-1]}}, c};
  endfunction

  task automatic clear_key_state();
    mix_word    = sbh_pkg::MIX_SEED;
    key_length  = '0;
    first_char  = '0;
    second_char = '0;
    prev_char   = '0;
    last_char   = '0;
  endtask

  // Folds one accepted key byte into the running state and, on the final byte,
  // queues the bucket index the block should give for the key.
  task automatic absorb_key_byte(input logic [sbh_pkg::BYTE_W-1:0] b, input logic ends);
    logic [sbh_pkg::WORD_W-1:0] h;
    logic [sbh_pkg::WORD_W-1:0] w;
    logic [sbh_pkg::WORD_W-1:0] hash;
    logic [sbh_pkg::BYTE_W-1:0] s;
    logic [sbh_pkg::BYTE_W-1:0] bl;
    bucket_result_t             res;
    if (b != '0) begin
      h = (mix_word ^ sign_widen(b)) * sbh_pkg::MIX_MUL;
      h = h ^ (h >> sbh_pkg::MIX_SHIFT);
      mix_word = h;
      if (key_length == 0) begin
        first_char = b;
      end else if (key_length == 1) begin
        second_char = b;
      end
      prev_char = last_char;
      last_char = b;
      if (key_length != sbh_pkg::LEN_MAX) begin
        key_length = key_length + 1;
      end
    end
    if (ends) begin
      if (key_length == 0) begin
        res.bucket_index = '0;
        res.key_empty    = 1'b1;
      end else begin
        // A one-byte key stands in for its own second and second-last bytes.
        s  = (key_length > 1) ? second_char : first_char;
        bl = (key_length > 1) ? prev_char : first_char;
        w  = (sign_widen(first_char) << 24) | (sign_widen(s) << 16)
           | (sign_widen(bl) << 8) | sign_widen(last_char);
        w  = (key_length < sbh_pkg::LEN_LIMIT) ? (w ^ ~key_length) : (w ^ key_length);
        hash = {mix_word[31:16], w[15:0]};
        res.bucket_index = (bucket_count_q != 0) ? (hash % bucket_count_q) : hash;
        res.key_empty    = 1'b0;
      end
      awaited_buckets.push_back(res);
      clear_key_state();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q = '0;
      clear_key_state();
      awaited_buckets.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (awaited_buckets.size() == 0) begin
          $error("bucket_index: expected none, got %h (key_empty %b)", m_tdata_i, m_tuser_i);
          mismatches++;
        end else begin
          oldest_bucket = awaited_buckets.pop_front();
          if (m_tdata_i !== oldest_bucket.bucket_index) begin
            $error("bucket_index: expected %h, got %h", oldest_bucket.bucket_index, m_tdata_i);
            mismatches++;
          end
          if (m_tuser_i !== oldest_bucket.key_empty) begin
            $error("key_empty: expected %b, got %b", oldest_bucket.key_empty, m_tuser_i);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        bucket_count_q = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        absorb_key_byte(s_tdata_i, s_tlast_i);
      end
    end
    waiting = awaited_buckets.size();
  end

endmodule

>>> dv/string_bucket_hash_tb.sv
// Testbench top for the string bucket hash: stimulus, flow control and verdict.
module string_bucket_hash_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Generous ceiling on the whole run; a correct run needs a small fraction of it.
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  // Quiet time after the last result: covers forming the hash and the
  // remainder unit's work, with margin.
  localparam int unsigned SETTLE_TICKS = 60;
  localparam int unsigned PHASE_BYTES  = 200;
  localparam int unsigned NUM_PHASES   = 7;
  localparam int unsigned HOLD_TICKS   = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] key_byte
  logic        s_axis_tlast;   // final byte of the key
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] bucket_index
  logic        m_axis_tuser;   // [0] key_empty

  int unsigned fail_count;
  int unsigned pending_buckets;
  int unsigned cycle_count;
  int unsigned nonzero_sent;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  bit          sink_hold;
  logic [31:0] bucket_counts[NUM_PHASES];

  string_bucket_hash u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  string_bucket_hash_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tlast_i     (s_axis_tlast),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tuser_i     (m_axis_tuser),
    .error_count_o (fail_count),
    .pending_o     (pending_buckets)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: if the run has not finished by the limit, something has hung.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Result side. Readiness is redrawn at every falling edge, so stalls land on
  // every phase of the block's work; a hold-off overrides the draw entirely.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Long back-pressure stretch: once the random traffic is under way the
  // receiver stops taking results for a good while. The output register and
  // the key behind it fill up, so the block must stall its byte input whilst
  // the sender keeps offering bytes.
  initial begin
    sink_hold = 1'b0;
    wait (nonzero_sent >= 150);
    @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (HOLD_TICKS) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  // Offers one key byte as a request and returns at the falling edge after it
  // has been taken. Idle gaps are put in before the byte, with tvalid low, so
  // tvalid is never dropped and raised again in one time step.
  task automatic send_key_byte(input logic [7:0] b, input logic ends);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= ends;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (b != 8'h00) nonzero_sent++;
    @(negedge clk_i);
  endtask

  // Nonzero byte values drawn evenly, printable and high-bit alike, with the odd
  // zero byte that the block must skip over.
  function automatic logic [7:0] random_char();
    if ($urandom_range(99) < 8) return 8'h00;
    return 8'($urandom_range(255, 1));
  endfunction

  // One random key. Most keys are ordinary strings of a few characters; some
  // are long, a few are empty, and some end on a zero byte carrying tlast.
  task automatic send_random_key();
    int unsigned shape;
    int unsigned len;
    bit          zero_end;
    shape = $urandom_range(99);
    if (shape < 5) begin
      len = $urandom_range(0, 0);
    end else if (shape < 85) begin
      len = $urandom_range(12, 1);
    end else begin
      len = $urandom_range(48, 13);
    end
    zero_end = (len == 0) || ($urandom_range(99) < 10);
    for (int unsigned k = 0; k < len; k++) begin
      send_key_byte(random_char(), !zero_end && (k == len - 1));
    end
    if (zero_end) send_key_byte(8'h00, 1'b1);
  endtask

  // Stops offering bytes, waits for every outstanding bucket index, then lets
  // the block settle so that a register write finds it idle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_buckets != 0) @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  // Writes bucket_count with a single request on the configuration channel.
  task automatic write_bucket_count(input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    nonzero_sent  = 0;
    src_idle_pct  = 28;
    sink_idle_pct = 64;

    // Bucket counts per phase: the extremes of the register, a power of two,
    // and a couple of random values, with zero revisited after a nonzero one.
    bucket_counts[0] = 32'd7;
    bucket_counts[1] = 32'hffff_ffff;
    bucket_counts[2] = 32'd1;
    bucket_counts[3] = $urandom();
    bucket_counts[4] = 32'd0;
    bucket_counts[5] = 32'($urandom_range(1000, 2));
    bucket_counts[6] = 32'h8000_0000;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed keys with bucket_count at its reset value of zero, so the raw
    // hash is visible. Single-byte key: first byte doubles as second and
    // second-last.
    send_key_byte(8'h41, 1'b1);
    // Two-byte key across both sign extremes.
    send_key_byte(8'h01, 1'b0);
    send_key_byte(8'hff, 1'b1);
    // Zero byte in the middle of a key is skipped.
    send_key_byte(8'h7f, 1'b0);
    send_key_byte(8'h80, 1'b0);
    send_key_byte(8'h00, 1'b0);
    send_key_byte(8'hc3, 1'b1);
    // Empty key: a lone zero byte with tlast.
    send_key_byte(8'h00, 1'b1);
    // Key that ends on a zero byte carrying tlast.
    send_key_byte(8'h55, 1'b0);
    send_key_byte(8'h00, 1'b1);
    // Key made only of zero bytes is empty as well.
    send_key_byte(8'h00, 1'b0);
    send_key_byte(8'h00, 1'b1);
    // Longer key with mixed signs for the second-last byte.
    send_key_byte(8'h80, 1'b0);
    send_key_byte(8'hff, 1'b0);
    send_key_byte(8'h7f, 1'b0);
    send_key_byte(8'h01, 1'b0);
    send_key_byte(8'haa, 1'b1);
    drain_results();

    // Random phases, one bucket count each. Idling runs receiver-heavy first,
    // then sender-heavy, then not at all.
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      if (p == 3) begin
        src_idle_pct  = 64;
        sink_idle_pct = 28;
      end else if (p == 5) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      write_bucket_count(bucket_counts[p]);
      begin
        int unsigned target;
        target = nonzero_sent + PHASE_BYTES;
        while (nonzero_sent < target) send_random_key();
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/sbh_pkg.sv
rtl/core/sbh_divider.sv
rtl/core/string_bucket_hash.sv
dv/string_bucket_hash_checker.sv
dv/string_bucket_hash_tb.sv
